>>> rtl/ilcr_pkg.sv
// Shared types, protocol codes and a ones'-complement fold helper for the checksum regenerator.
package ilcr_pkg;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TCP  = 2'd1;
  localparam logic [1:0] KIND_UDP  = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hffff;
  localparam logic [3:0]  MIN_IHL   = 4'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] ip_checksum;
    logic [15:0] l4_checksum;
    logic [1:0]  l4_kind;
    logic        length_error;
  } result_t;

  // Per-packet totals captured when the last byte is taken.
  typedef struct packed {
    logic [15:0] byte_count;
    logic [3:0]  header_words;
    logic [15:0] total_length;
    logic [7:0]  protocol_number;
    logic [15:0] udp_length;
    logic [15:0] ip_sum;
    logic [15:0] l4_sum;
  } snap_t;

  // Fold an 18-bit sum of up to four 16-bit terms with end-around carry.
  function automatic logic [15:0] oc_fold(input logic [17:0] x);
    logic [16:0] t;
    t = {1'b0, x[15:0]} + {15'd0, x[17:16]};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

>>> rtl/ilcr_accum.sv
// Per-byte accumulator: running IP and TCP/UDP sums and captured header fields.
module ilcr_accum import ilcr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_item_t byte_item,
  output logic       snap_valid,
  input  logic       snap_stall,
  output snap_t      snap
);

  logic [15:0] byte_count;
  logic [15:0] ip_sum;
  logic [15:0] l4_sum;
  logic [3:0]  header_words;
  logic [15:0] total_length;
  logic [7:0]  protocol_number;
  logic [15:0] udp_length;
  logic [31:0] udp_hold;

  logic [15:0] byte_count_next;
  logic [15:0] ip_sum_next;
  logic [15:0] l4_sum_next;
  logic [3:0]  header_words_next;
  logic [15:0] total_length_next;
  logic [7:0]  protocol_number_next;
  logic [15:0] udp_length_next;
  logic [31:0] udp_hold_next;

  logic        accept;
  logic        take;
  logic [7:0]  b;
  logic [15:0] o;
  logic [3:0]  hw_eff;
  logic [15:0] hl16;
  logic [15:0] tlen_eff;
  logic [7:0]  proto_eff;
  logic [15:0] placed;
  logic [15:0] ip_add;
  logic [15:0] s;
  logic [15:0] tl;
  logic [15:0] ul_eff;
  logic [31:0] hold_eff;
  logic [15:0] w0, w1, w2;
  logic [15:0] ip_sum_upd;
  logic [15:0] l4_sum_upd;

  assign byte_stall = snap_valid && snap_stall;
  assign accept     = byte_valid && !byte_stall;

  assign b      = byte_item.data_byte;
  assign o      = byte_count;
  assign take   = (byte_count != COUNT_MAX);
  assign hw_eff = (o == 16'd0) ? b[3:0] : header_words;
  assign hl16   = {10'd0, hw_eff, 2'b00};
  assign placed = o[0] ? {8'd0, b} : {b, 8'd0};
  assign s      = o - hl16;

  always_comb begin
    tlen_eff = total_length;
    if (o == 16'd2) tlen_eff = {b, total_length[7:0]};
    if (o == 16'd3) tlen_eff = {total_length[15:8], b};
  end

  assign proto_eff = (o == 16'd9) ? b : protocol_number;
  assign tl        = tlen_eff - hl16;
  assign ip_add    = ((o < hl16) && (o != 16'd10) && (o != 16'd11)) ? placed : 16'd0;

  // Transport contributions; the header span and the payload span never overlap.
  always_comb begin
    w0       = 16'd0;
    w1       = 16'd0;
    w2       = 16'd0;
    ul_eff   = udp_length;
    hold_eff = udp_hold;
    if (hw_eff >= MIN_IHL) begin
      if (o >= 16'd12 && o < 16'd20) begin
        w0 = placed;
      end else if (o >= hl16) begin
        if (proto_eff == PROTO_TCP) begin
          if (s < tl && s != 16'd16 && s != 16'd17) w0 = placed;
        end else if (proto_eff == PROTO_UDP) begin
          if (s < 16'd4) begin
            unique case (s[1:0])
              2'd0: hold_eff[31:24] = b;
              2'd1: hold_eff[23:16] = b;
              2'd2: hold_eff[15:8]  = b;
              2'd3: hold_eff[7:0]   = b;
            endcase
          end else if (s == 16'd4) begin
            ul_eff = {b, udp_length[7:0]};
          end else if (s == 16'd5) begin
            // Length field complete: add the held header bytes that lie inside it.
            ul_eff = {udp_length[15:8], b};
            w0 = {(ul_eff > 16'd0) ? udp_hold[31:24] : 8'd0,
                  (ul_eff > 16'd1) ? udp_hold[23:16] : 8'd0};
            w1 = {(ul_eff > 16'd2) ? udp_hold[15:8] : 8'd0,
                  (ul_eff > 16'd3) ? udp_hold[7:0] : 8'd0};
            w2 = {(ul_eff > 16'd4) ? udp_length[15:8] : 8'd0,
                  (ul_eff > 16'd5) ? b : 8'd0};
          end else if (s >= 16'd8 && s < udp_length) begin
            w0 = placed;
          end
        end
      end
    end
  end

  assign ip_sum_upd = oc_fold({2'b00, ip_sum} + {2'b00, ip_add});
  assign l4_sum_upd = oc_fold({2'b00, l4_sum} + {2'b00, w0} + {2'b00, w1} + {2'b00, w2});

  // Past the counter limit, drop the byte and hold everything.
  always_comb begin
    byte_count_next      = byte_count;
    ip_sum_next          = ip_sum;
    l4_sum_next          = l4_sum;
    header_words_next    = header_words;
    total_length_next    = total_length;
    protocol_number_next = protocol_number;
    udp_length_next      = udp_length;
    udp_hold_next        = udp_hold;
    if (take) begin
      byte_count_next      = byte_count + 16'd1;
      ip_sum_next          = ip_sum_upd;
      l4_sum_next          = l4_sum_upd;
      header_words_next    = hw_eff;
      total_length_next    = tlen_eff;
      protocol_number_next = proto_eff;
      udp_length_next      = ul_eff;
      udp_hold_next        = hold_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid      <= 1'b0;
      byte_count      <= 16'd0;
      ip_sum          <= 16'd0;
      l4_sum          <= 16'd0;
      header_words    <= 4'd0;
      total_length    <= 16'd0;
      protocol_number <= 8'd0;
      udp_length      <= 16'd0;
      udp_hold        <= 32'd0;
    end else begin
      if (accept && byte_item.last) begin
        snap_valid <= 1'b1;
      end else if (snap_valid && !snap_stall) begin
        snap_valid <= 1'b0;
      end
      if (accept) begin
        if (byte_item.last) begin
          byte_count      <= 16'd0;
          ip_sum          <= 16'd0;
          l4_sum          <= 16'd0;
          header_words    <= 4'd0;
          total_length    <= 16'd0;
          protocol_number <= 8'd0;
          udp_length      <= 16'd0;
          udp_hold        <= 32'd0;
        end else begin
          byte_count      <= byte_count_next;
          ip_sum          <= ip_sum_next;
          l4_sum          <= l4_sum_next;
          header_words    <= header_words_next;
          total_length    <= total_length_next;
          protocol_number <= protocol_number_next;
          udp_length      <= udp_length_next;
          udp_hold        <= udp_hold_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_item.last) begin
      snap.byte_count      <= byte_count_next;
      snap.header_words    <= header_words_next;
      snap.total_length    <= total_length_next;
      snap.protocol_number <= protocol_number_next;
      snap.udp_length      <= udp_length_next;
      snap.ip_sum          <= ip_sum_next;
      snap.l4_sum          <= l4_sum_next;
    end
  end

endmodule

>>> rtl/ilcr_final.sv
// Finish stage: pseudo-header add, complement, length checks and result register.
module ilcr_final import ilcr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    snap_valid,
  output logic    snap_stall,
  input  snap_t   snap,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic        load;
  logic [15:0] hl16;
  logic [15:0] tl;
  logic [16:0] tcp_end;
  logic [16:0] udp_end;
  logic [16:0] udp_hdr_end;
  logic [16:0] cnt17;
  logic        is_tcp;
  logic        is_udp;
  logic        hw_ok;
  logic [15:0] l4_len;
  logic [15:0] l4_fold;
  result_t     result_next;

  assign snap_stall = result_valid && result_stall;
  assign load       = snap_valid && !snap_stall;

  assign hl16        = {10'd0, snap.header_words, 2'b00};
  assign tl          = snap.total_length - hl16;
  assign cnt17       = {1'b0, snap.byte_count};
  assign tcp_end     = {1'b0, hl16} + {1'b0, tl};
  assign udp_end     = {1'b0, hl16} + {1'b0, snap.udp_length};
  assign udp_hdr_end = {1'b0, hl16} + 17'd6;
  assign hw_ok       = (snap.header_words >= MIN_IHL);
  assign is_tcp      = hw_ok && (snap.protocol_number == PROTO_TCP);
  assign is_udp      = hw_ok && (snap.protocol_number == PROTO_UDP);
  assign l4_len      = is_tcp ? tl : snap.udp_length;
  assign l4_fold     = oc_fold({2'b00, snap.l4_sum} + {10'd0, snap.protocol_number}
                               + {2'b00, l4_len});

  always_comb begin
    result_next.ip_checksum  = ~snap.ip_sum;
    result_next.l4_checksum  = 16'd0;
    result_next.l4_kind      = KIND_NONE;
    result_next.length_error = !hw_ok || (snap.byte_count < hl16)
                               || (snap.byte_count < snap.total_length);
    if (is_tcp) begin
      result_next.l4_kind     = KIND_TCP;
      result_next.l4_checksum = ~l4_fold;
      if (cnt17 < tcp_end) result_next.length_error = 1'b1;
    end else if (is_udp) begin
      result_next.l4_kind     = KIND_UDP;
      result_next.l4_checksum = ~l4_fold;
      if (cnt17 < udp_hdr_end || cnt17 < udp_end) result_next.length_error = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule

>>> rtl/ipv4_l4_checksum_regen_top.sv
// Path: a packet's totals are registered in the snapshot, then in the result register.
// Throughput: one byte transaction per cycle when not stalled, back to back across packet
//   boundaries; the byte accumulator and the finish stage each hold one register stage.
// Stalls: the snapshot register and the result register hold under stall, and byte input
//   stalls only while both of them are full and the result is stalled.
// Reset: rst (synchronous) clears all per-packet sums and fields and drops pending results.
module ipv4_l4_checksum_regen_top import ilcr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_item_t byte_item,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result
);

  // Snapshot of one packet's totals, passed from the accumulator to the finish stage.
  logic  snap_valid;
  logic  snap_stall;
  snap_t snap;

  // Fold every byte into the running IP header sum and transport sum; capture the
  // totals and clear per-packet state on the last byte.
  ilcr_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .snap_valid (snap_valid),
    .snap_stall (snap_stall),
    .snap       (snap)
  );

  // Add the pseudo-header protocol and length, complement, check the lengths and
  // register the result transaction.
  ilcr_final u_final (
    .clk          (clk),
    .rst          (rst),
    .snap_valid   (snap_valid),
    .snap_stall   (snap_stall),
    .snap         (snap),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTH
  // Input must back up whenever the snapshot stage is blocked.
  a_stall_backs_up: assert property (@(posedge clk) disable iff (rst)
    (snap_valid && snap_stall) |-> byte_stall)
    else $error("byte input not stalled while snapshot stage is blocked");

  // A last byte always produces a snapshot in the next cycle.
  a_last_makes_snap: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && !byte_stall && byte_item.last) |=> snap_valid)
    else $error("last byte accepted but no snapshot formed");

  // A snapshot taken by the finish stage shows up as a result in the next cycle.
  a_snap_to_result: assert property (@(posedge clk) disable iff (rst)
    (snap_valid && !snap_stall) |=> result_valid)
    else $error("snapshot consumed but no result registered");

  // Without a transport protocol the transport checksum reads zero.
  a_no_kind_zero_sum: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.l4_kind == KIND_NONE) |-> (result.l4_checksum == 16'd0))
    else $error("transport checksum nonzero with no transport protocol");
`endif

endmodule
